### hdl/tadt_pkg.sv
// ----------------------------------------------------------------------------
// Thermal alarm and display throttle package
// Shared widths, register indexes, reset values and the item and state
// records that pass between the core and its evaluation logic.
// ----------------------------------------------------------------------------
package tadt_pkg;

   localparam int TimeWidth     = 32;
   localparam int TempWidth     = 10;
   localparam int FanWidth      = 11;
   localparam int CfgWidth      = 10;
   localparam int CsrIndexWidth = 3;

   // Temperature at or below which a stopped fan is sampled less often.
   localparam logic [TempWidth-1:0] QUIET_TEMP = 10'd46;
   // Temperature steps larger than this are shown at once, without waiting for a refresh.
   localparam logic [TempWidth-1:0] TEMP_HYSTERESIS = 10'd2;

   typedef enum logic [CsrIndexWidth-1:0] {
      REG_FAN_CHECK_PERIOD   = 3'd0,
      REG_WARN_THRESHOLD     = 3'd1,
      REG_WARN_REPEAT_PERIOD = 3'd2,
      REG_REFRESH_PERIOD     = 3'd3,
      REG_BEEP_ENABLE        = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [CfgWidth-1:0] fan_check_period;
      logic [CfgWidth-1:0] warn_threshold;
      logic [CfgWidth-1:0] warn_repeat_period;
      logic [CfgWidth-1:0] refresh_period;
      logic                beep_enable;
   } cfg_type;

   typedef struct packed {
      logic        [TempWidth-1:0] shown_temp;
      logic signed [FanWidth-1:0]  shown_fan;
      logic        [TimeWidth-1:0] alarm_time;
      logic        [TimeWidth-1:0] fan_time;
      logic        [TimeWidth-1:0] refresh_time;
   } state_type;

   typedef struct packed {
      logic        [TimeWidth-1:0] now_seconds;
      logic        [TempWidth-1:0] temperature;
      logic signed [FanWidth-1:0]  fan_sample;
      logic                        force_req;
   } tick_type;

   typedef struct packed {
      logic                        fan_taken;
      logic                        alarm;
      logic                        beep;
      logic                        refresh;
      logic                        show_label;
      logic                        show_fan;
      logic        [TempWidth-1:0] shown_temperature;
      logic signed [FanWidth-1:0]  shown_fan;
   } result_type;

   localparam cfg_type CFG_RESET = '{
      fan_check_period:   10'd9,
      warn_threshold:     10'd90,
      warn_repeat_period: 10'd15,
      refresh_period:     10'd6,
      beep_enable:        1'b0
   };

   localparam state_type STATE_RESET = '{
      shown_temp:   '0,
      shown_fan:    '1,
      alarm_time:   '0,
      fan_time:     '0,
      refresh_time: '0
   };

endpackage

### hdl/tadt_eval.sv
// ----------------------------------------------------------------------------
// Thermal alarm and display throttle evaluation
// Decides fan sampling, alarm and display refresh for one tick and forms
// the next state and the result item.
// ----------------------------------------------------------------------------
module tadt_eval (
   input  tadt_pkg::cfg_type    cfg,
   input  tadt_pkg::state_type  state,
   input  tadt_pkg::tick_type   tick,
   output tadt_pkg::state_type  state_next,
   output tadt_pkg::result_type result
);

   localparam int SumWidth  = tadt_pkg::TimeWidth + 1;
   localparam int SpanWidth = tadt_pkg::CfgWidth + 2;

   logic                                slow_check;
   logic        [SpanWidth-1:0]         fan_span;
   logic        [SumWidth-1:0]          now_ext;
   logic                                fan_due;
   logic                                taken;
   logic                                alarm;
   logic                                hot_now;
   logic signed [tadt_pkg::FanWidth-1:0]  fan;
   logic        [tadt_pkg::TempWidth-1:0] diff;
   logic                                temp_changed;
   logic                                fan_changed;
   logic                                refresh_due;
   logic                                refresh;

   assign now_ext = {1'b0, tick.now_seconds};

   // A stopped fan at a cool temperature is checked three times less often.
   assign slow_check = (state.shown_fan == '0) && (tick.temperature <= tadt_pkg::QUIET_TEMP);
   assign fan_span   = slow_check ?
                       ({1'b0, cfg.fan_check_period, 1'b0} + {2'b00, cfg.fan_check_period}) :
                       {2'b00, cfg.fan_check_period};
   assign fan_due    = now_ext > ({1'b0, state.fan_time} + SumWidth'(fan_span));

   assign temp_changed = tick.temperature != state.shown_temp;
   assign taken        = tick.force_req || temp_changed || fan_due;
   assign fan          = taken ? tick.fan_sample : state.shown_fan;

   assign hot_now = tick.temperature >= cfg.warn_threshold;
   assign alarm   = hot_now &&
                    (now_ext >= ({1'b0, state.alarm_time} + SumWidth'(cfg.warn_repeat_period)));

   assign diff = (tick.temperature > state.shown_temp) ? tick.temperature - state.shown_temp :
                                                         state.shown_temp - tick.temperature;
   assign fan_changed = fan != state.shown_fan;
   assign refresh_due = now_ext >= ({1'b0, state.refresh_time} +
                                    SumWidth'(cfg.refresh_period));
   assign refresh = (temp_changed || fan_changed) &&
                    (tick.force_req || (diff > tadt_pkg::TEMP_HYSTERESIS) || hot_now ||
                     (state.shown_temp >= cfg.warn_threshold) || fan_changed || refresh_due);

   always_comb begin
      state_next = state;
      if (taken) begin
         state_next.fan_time = tick.now_seconds;
      end
      if (alarm) begin
         state_next.alarm_time = tick.now_seconds;
      end
      if (refresh) begin
         state_next.shown_temp   = tick.temperature;
         state_next.shown_fan    = fan;
         state_next.refresh_time = tick.now_seconds;
      end
   end

   always_comb begin
      result.fan_taken         = taken;
      result.alarm             = alarm;
      result.beep              = alarm && cfg.beep_enable;
      result.refresh           = refresh;
      result.show_label        = state_next.shown_temp != '0;
      result.show_fan          = (state_next.shown_temp != '0) && (state_next.shown_fan > 0);
      result.shown_temperature = state_next.shown_temp;
      result.shown_fan         = state_next.shown_fan;
   end

endmodule

### hdl/thermal_alarm_display_throttle_core.sv
// ----------------------------------------------------------------------------
// Thermal alarm and display throttle core
// Per-tick fan sampling, over-temperature alarm and display refresh control.
// ----------------------------------------------------------------------------
// Usage:
// Each item on the req_ channel is one tick: time in seconds, temperature,
// fan sample and a force flag. For every accepted item the block returns
// exactly one result item on the rsp_ channel, in order: whether the fan
// sample was taken, alarm and beep flags, whether the display refreshed,
// and the values now on the display.
// The block runs at one item per cycle while rsp_tready is held high. An item
// sits in the input register while the evaluation logic compares it against
// the stored last-shown values and times; the result register is loaded from
// it whenever the result register is empty or being drained. The state feeds
// back as each result is loaded, so the next item sees it; this sets the rate.
// If the receiver holds rsp_tready low, the result register holds its item
// and the input register can still take one more; req_tready drops only
// when both are full. Nothing is lost or repeated under stalls.
// Registers are written over the csr_ channel (always ready); the user must
// write them only while the block is idle; the block does not enforce it.
// Indexes beyond the register list are ignored. Reset clears both pipeline
// registers, loads the reset values and shows temperature 0, fan speed -1.
// ----------------------------------------------------------------------------
module thermal_alarm_display_throttle_core (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   // [31:0] now_seconds, [41:32] temperature, [52:42] fan_sample, [55:53] zero
   input  logic [55:0] req_tdata,
   // [0] force_req
   input  logic [0:0]  req_tuser,

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] fan_taken, [1] alarm, [2] beep, [3] refresh, [4] show_label,
   // [5] show_fan, [15:6] shown_temperature, [26:16] shown_fan, [31:27] zero
   output logic [31:0] rsp_tdata,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tadt_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [tadt_pkg::CfgWidth-1:0]        csr_data
);

   tadt_pkg::tick_type   tick_ff,      tick_in;
   logic                 in_valid_ff,  in_valid_in;
   tadt_pkg::result_type result_ff,    result_in;
   logic                 out_valid_ff, out_valid_in;
   tadt_pkg::state_type  state_ff,     state_in;
   tadt_pkg::cfg_type    cfg_ff,       cfg_in;

   tadt_pkg::state_type  state_next;
   tadt_pkg::result_type result_next;

   logic req_accept;
   logic advance;

   // The held item moves on whenever the result register is empty or being
   // drained in this cycle.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   tadt_eval u_eval (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .tick       (tick_ff),
      .state_next (state_next),
      .result     (result_next)
   );

   always_comb begin
      tick_in = tick_ff;
      if (req_accept) begin
         tick_in.now_seconds = req_tdata[31:0];
         tick_in.temperature = req_tdata[41:32];
         tick_in.fan_sample  = req_tdata[52:42];
         tick_in.force_req   = req_tuser[0];
      end
      in_valid_in = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   end

   always_comb begin
      result_in    = advance ? result_next : result_ff;
      state_in     = advance ? state_next : state_ff;
      out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   // Register writes; the data is cut to the width of each register.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            tadt_pkg::REG_FAN_CHECK_PERIOD:   cfg_in.fan_check_period   = csr_data;
            tadt_pkg::REG_WARN_THRESHOLD:     cfg_in.warn_threshold     = csr_data;
            tadt_pkg::REG_WARN_REPEAT_PERIOD: cfg_in.warn_repeat_period = csr_data;
            tadt_pkg::REG_REFRESH_PERIOD:     cfg_in.refresh_period     = csr_data;
            tadt_pkg::REG_BEEP_ENABLE:        cfg_in.beep_enable        = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      tick_ff   <= tick_in;
      result_ff <= result_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= tadt_pkg::STATE_RESET;
         cfg_ff       <= tadt_pkg::CFG_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b00000,
                        result_ff.shown_fan,
                        result_ff.shown_temperature,
                        result_ff.show_fan,
                        result_ff.show_label,
                        result_ff.refresh,
                        result_ff.beep,
                        result_ff.alarm,
                        result_ff.fan_taken};

endmodule
